[src/svpc_pkg.sv]
package svpc_pkg;

   localparam int VB = 16;
   localparam int FB = 16;
   localparam int PW = 16;
   localparam int KW = VB + 18;
   localparam int NW = VB + FB + 5;
   localparam int DW = NW - 1;
   localparam int RW = DW + 3;
   localparam int QW = FB + 2;
   localparam int TW = FB + 7;
   localparam int MW = TW - 1 + PW;

   localparam logic [17:0] SQRT3_Q = 18'd113512;
   localparam logic [PW-1:0] PERIOD_RESET = 16'd5000;

   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

   localparam logic [2:0] SIGN_110 = 3'd1;
   localparam logic [2:0] SIGN_260 = 3'd2;
   localparam logic [2:0] SIGN_220 = 3'd4;
   localparam logic [2:0] SIGN_170 = 3'd5;
   localparam logic [2:0] SIGN_290 = 3'd6;

   typedef struct packed {
      logic signed [VB-1:0] volt_alpha;
      logic signed [VB-1:0] volt_beta;
      logic [VB-1:0]        bus_voltage;
   } req_type;

   typedef struct packed {
      logic [PW-1:0] cmp_a;
      logic [PW-1:0] cmp_b;
      logic [PW-1:0] cmp_c;
      logic [2:0]    sector;
      logic          overmodulated;
      logic          bus_fault;
   } rsp_type;

   typedef struct packed {
      logic [RW-1:0] rem1;
      logic [RW-1:0] rem2;
      logic [RW-1:0] dd;
      logic [QW-1:0] q1;
      logic [QW-1:0] q2;
      logic          neg1;
      logic          neg2;
      logic          sat1;
      logic          sat2;
      logic [2:0]    sector;
      logic          om;
      logic          fault;
   } div_type;

   function automatic logic [2:0] sector_of(input logic [2:0] code);
      logic [2:0] s;
      unique case (code)
         SIGN_110: s = SECTOR_2;
         SIGN_260: s = SECTOR_6;
         SIGN_220: s = SECTOR_4;
         SIGN_170: s = SECTOR_3;
         SIGN_290: s = SECTOR_5;
         default:  s = SECTOR_1;
      endcase
      return s;
   endfunction

endpackage

[src/svpc_front.sv]
module svpc_front
   import svpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   localparam logic signed [KW-1:0] SQRT3_K = KW'(SQRT3_Q);

   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d;

   // stage a: sqrt3 products
   logic signed [VB-1:0] a_ff, b_ff;
   logic [VB-1:0]        udc_a_ff;
   logic signed [KW-1:0] kua_ff, kub_ff, kua_in, kub_in;

   // stage b: sector and dwell numerators
   logic signed [NW-1:0] a_w, b_w, kua_w, kub_w, ubs, a3, nx, ny, nz;
   logic signed [NW-1:0] n1_in, n2_in, n1_ff, n2_ff;
   logic [2:0]           code, sec_in, sec_b_ff;
   logic [VB-1:0]        udc_b_ff;

   // stage c: overmodulation test and denominator
   logic [DW-1:0]        d_w, den_in, den_ff;
   logic signed [NW-1:0] sum, n1c_ff, n2c_ff;
   logic                 fault_in, om_in, fault_ff, om_ff;
   logic [2:0]           sec_c_ff;

   // stage d: magnitudes and saturation
   logic [NW-1:0] m1, m2;
   logic [RW-1:0] den4;
   div_type       out_in, out_ff;

   assign rdy_d    = !vd_ff || out_ready;
   assign rdy_c    = !vc_ff || rdy_d;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      kua_in = KW'(in_data.volt_alpha) * SQRT3_K;
      kub_in = KW'(in_data.volt_beta) * SQRT3_K;
   end

   always_comb begin
      a_w    = NW'(a_ff);
      b_w    = NW'(b_ff);
      kua_w  = NW'(kua_ff);
      kub_w  = NW'(kub_ff);
      ubs    = b_w <<< FB;
      a3     = (a_w <<< FB) + (a_w <<< (FB + 1));
      nx     = kub_w <<< 1;
      ny     = kub_w + a3;
      nz     = kub_w - a3;
      code   = {(-kua_w - ubs) > 0, (kua_w - ubs) > 0, b_w >= 0};
      sec_in = sector_of(code);
      unique case (sec_in)
         SECTOR_1: begin n1_in = -nz; n2_in = nx;  end
         SECTOR_2: begin n1_in = nz;  n2_in = ny;  end
         SECTOR_3: begin n1_in = nx;  n2_in = -ny; end
         SECTOR_4: begin n1_in = -nx; n2_in = nz;  end
         SECTOR_5: begin n1_in = -ny; n2_in = -nz; end
         default:  begin n1_in = ny;  n2_in = -nx; end
      endcase
   end

   always_comb begin
      d_w      = DW'(udc_b_ff) << (FB + 1);
      sum      = n1_ff + n2_ff;
      fault_in = (udc_b_ff == '0);
      om_in    = !fault_in && (sum > signed'({1'b0, d_w}));
      den_in   = om_in ? DW'(sum) : d_w;
   end

   always_comb begin
      m1            = n1c_ff[NW-1] ? NW'(-n1c_ff) : NW'(n1c_ff);
      m2            = n2c_ff[NW-1] ? NW'(-n2c_ff) : NW'(n2c_ff);
      den4          = RW'(den_ff) << 2;
      out_in.rem1   = RW'(m1);
      out_in.rem2   = RW'(m2);
      out_in.dd     = RW'(den_ff) << 1;
      out_in.q1     = '0;
      out_in.q2     = '0;
      out_in.neg1   = n1c_ff[NW-1];
      out_in.neg2   = n2c_ff[NW-1];
      out_in.sat1   = RW'(m1) >= den4;
      out_in.sat2   = RW'(m2) >= den4;
      out_in.sector = sec_c_ff;
      out_in.om     = om_ff;
      out_in.fault  = fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         a_ff     <= in_data.volt_alpha;
         b_ff     <= in_data.volt_beta;
         udc_a_ff <= in_data.bus_voltage;
         kua_ff   <= kua_in;
         kub_ff   <= kub_in;
      end
      if (rdy_b && va_ff) begin
         n1_ff    <= n1_in;
         n2_ff    <= n2_in;
         sec_b_ff <= sec_in;
         udc_b_ff <= udc_a_ff;
      end
      if (rdy_c && vb_ff) begin
         n1c_ff   <= n1_ff;
         n2c_ff   <= n2_ff;
         den_ff   <= den_in;
         om_ff    <= om_in;
         fault_ff <= fault_in;
         sec_c_ff <= sec_b_ff;
      end
      if (rdy_d && vc_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = vd_ff;
   assign out_data  = out_ff;

endmodule

[src/svpc_div_step.sv]
module svpc_div_step
   import svpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic          v_ff;
   logic          ge1, ge2;
   logic [RW-1:0] rs1, rs2;
   div_type       d_in, d_ff;

   assign in_ready = !v_ff || out_ready;

   // one restoring quotient bit for each of the two dwell divisions
   always_comb begin
      ge1     = in_data.rem1 >= in_data.dd;
      ge2     = in_data.rem2 >= in_data.dd;
      rs1     = ge1 ? in_data.rem1 - in_data.dd : in_data.rem1;
      rs2     = ge2 ? in_data.rem2 - in_data.dd : in_data.rem2;
      d_in    = in_data;
      d_in.rem1 = rs1 << 1;
      d_in.rem2 = rs2 << 1;
      d_in.q1 = {in_data.q1[QW-2:0], ge1};
      d_in.q2 = {in_data.q2[QW-2:0], ge2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

[src/svpc_back.sv]
module svpc_back
   import svpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [PW-1:0] period,
   input  logic          in_valid,
   output logic          in_ready,
   input  div_type       in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_type       out_data
);

   localparam logic signed [TW-1:0] T_ONE = TW'(1 << FB);
   localparam logic [TW-1:0]        T_SAT = TW'(1 << (FB + 2));

   logic ve_ff, vf_ff, vg_ff;
   logic rdy_e, rdy_f, rdy_g;

   // stage e: phase times
   logic [TW-1:0]        qf1, qf2;
   logic signed [TW-1:0] t1, t2, ta, tb, tc;
   logic signed [TW-1:0] pa_in, pb_in, pc_in, pa_ff, pb_ff, pc_ff;
   logic [2:0]           sec_e_ff, sec_f_ff;
   logic                 om_e_ff, fault_e_ff, om_f_ff, fault_f_ff;

   // stage f: scale by period
   logic [MW-1:0] ma_in, mb_in, mc_in, ma_ff, mb_ff, mc_ff;

   // stage g: shift, clamp, fault select
   logic [MW-FB-2:0] va, vb, vc;
   rsp_type          rsp_in, rsp_ff;

   assign rdy_g    = !vg_ff || out_ready;
   assign rdy_f    = !vf_ff || rdy_g;
   assign rdy_e    = !ve_ff || rdy_f;
   assign in_ready = rdy_e;

   always_comb begin
      qf1 = in_data.sat1 ? T_SAT : TW'(in_data.q1);
      qf2 = in_data.sat2 ? T_SAT : TW'(in_data.q2);
      t1  = in_data.neg1 ? -signed'(qf1) : signed'(qf1);
      t2  = in_data.neg2 ? -signed'(qf2) : signed'(qf2);
      ta  = T_ONE - t1 - t2;
      tb  = ta + (t1 <<< 1);
      tc  = tb + (t2 <<< 1);
      unique case (in_data.sector)
         SECTOR_1: begin pa_in = ta; pb_in = tb; pc_in = tc; end
         SECTOR_2: begin pa_in = tb; pb_in = ta; pc_in = tc; end
         SECTOR_3: begin pa_in = tc; pb_in = ta; pc_in = tb; end
         SECTOR_4: begin pa_in = tc; pb_in = tb; pc_in = ta; end
         SECTOR_5: begin pa_in = tb; pb_in = tc; pc_in = ta; end
         default:  begin pa_in = ta; pb_in = tc; pc_in = tb; end
      endcase
   end

   always_comb begin
      ma_in = (pa_ff > 0) ? MW'(pa_ff[TW-2:0]) * MW'(period) : '0;
      mb_in = (pb_ff > 0) ? MW'(pb_ff[TW-2:0]) * MW'(period) : '0;
      mc_in = (pc_ff > 0) ? MW'(pc_ff[TW-2:0]) * MW'(period) : '0;
   end

   always_comb begin
      va = ma_ff[MW-1:FB+1];
      vb = mb_ff[MW-1:FB+1];
      vc = mc_ff[MW-1:FB+1];
      if (fault_f_ff) begin
         rsp_in.cmp_a = period >> 1;
         rsp_in.cmp_b = period >> 1;
         rsp_in.cmp_c = period >> 1;
      end else begin
         rsp_in.cmp_a = (va > (MW-FB-1)'(period)) ? period : va[PW-1:0];
         rsp_in.cmp_b = (vb > (MW-FB-1)'(period)) ? period : vb[PW-1:0];
         rsp_in.cmp_c = (vc > (MW-FB-1)'(period)) ? period : vc[PW-1:0];
      end
      rsp_in.sector        = sec_f_ff;
      rsp_in.overmodulated = om_f_ff;
      rsp_in.bus_fault     = fault_f_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else begin
         if (rdy_e) ve_ff <= in_valid;
         if (rdy_f) vf_ff <= ve_ff;
         if (rdy_g) vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_e && in_valid) begin
         pa_ff      <= pa_in;
         pb_ff      <= pb_in;
         pc_ff      <= pc_in;
         sec_e_ff   <= in_data.sector;
         om_e_ff    <= in_data.om;
         fault_e_ff <= in_data.fault;
      end
      if (rdy_f && ve_ff) begin
         ma_ff      <= ma_in;
         mb_ff      <= mb_in;
         mc_ff      <= mc_in;
         sec_f_ff   <= sec_e_ff;
         om_f_ff    <= om_e_ff;
         fault_f_ff <= fault_e_ff;
      end
      if (rdy_g && vf_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vg_ff;
   assign out_data  = rsp_ff;

endmodule

[src/space_vector_pwm_compare.sv]
// Space vector PWM compare generator. Each transfer on req_ carries an alpha/beta voltage
// reference and the DC bus voltage; one transfer on rsp_ returns the three phase compare
// counts (0 to period), the sector, an overmodulation flag and a bus fault flag. A new item
// is taken every cycle unless req_stall is high; the pipeline holds four front stages
// (sqrt3 products, sector and dwell numerators, overmodulation test, magnitudes), eighteen
// stages of the bit-per-stage restoring divider for the two dwell times, and three back
// stages (phase times, period scaling, clamp). Stall on rsp_ holds only as many stages as
// are full, so bubbles close up. csr_write_data sets the PWM period (reset 5000) and is to
// be written only while no item is in flight.
module space_vector_pwm_compare
   import svpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_write_enable,
   input  logic [PW-1:0] csr_write_data
);

   logic [PW-1:0] period_ff;
   logic          front_ready, back_ready;
   logic [QW:0]   dv_valid, dv_ready;
   div_type       dv_data [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   assign req_stall = !front_ready;

   svpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (dv_valid[0]),
      .out_ready (dv_ready[0]),
      .out_data  (dv_data[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_div
      svpc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[i]),
         .in_ready  (dv_ready[i]),
         .in_data   (dv_data[i]),
         .out_valid (dv_valid[i+1]),
         .out_ready (dv_ready[i+1]),
         .out_data  (dv_data[i+1])
      );
   end

   assign dv_ready[QW] = back_ready;

   svpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .period    (period_ff),
      .in_valid  (dv_valid[QW]),
      .in_ready  (back_ready),
      .in_data   (dv_data[QW]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sector >= SECTOR_1 && rsp_data.sector <= SECTOR_6))
      else $error("sector out of range");

   a_fault_no_om: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bus_fault |-> !rsp_data.overmodulated)
      else $error("overmodulation flagged with bus fault");

   a_cmp_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cmp_a <= period_ff && rsp_data.cmp_b <= period_ff
                     && rsp_data.cmp_c <= period_ff))
      else $error("compare beyond period");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import svpc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_enable = 1'b0;
   logic [PW-1:0] csr_write_data = '0;

   localparam int LATENCY = 25;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      req_type stim;
      bit      has_answer;
      rsp_type answer;
   } row_type;

   rsp_type    pending_cmps[$];
   logic [15:0] period_shadow = PERIOD_RESET;
   int         fail_count = 0;
   int         idle_cycles = 0;
   bit         hold_off = 1'b0;

   space_vector_pwm_compare uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint dwell_fraction(longint num, longint den);
      bit neg;
      longint a, q, r;
      neg = num < 0;
      a = neg ? -num : num;
      q = a / den;
      r = a % den;
      if (q >= 4) begin
         q = longint'(4) << 16;
      end else begin
         for (int i = 0; i < 16; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= den) begin
               r = r - den;
               q = q | 1;
            end
         end
      end
      return neg ? -q : q;
   endfunction

   function automatic logic [15:0] phase_count(longint t4, logic [15:0] per);
      longint v;
      if (t4 <= 0) return 16'd0;
      v = (t4 * longint'(per)) >>> 17;
      return v > per ? per : v[15:0];
   endfunction

   function automatic rsp_type svpwm_compares(req_type r, logic [15:0] per);
      rsp_type o;
      longint ua, ub, udc, kua, ubs, kub, a3, nx, ny, nz, d, n1, n2, den, t1, t2, ta, tb, tc;
      logic [2:0] code, sec;
      logic [15:0] pa, pb, pc;
      ua = longint'(r.volt_alpha);
      ub = longint'(r.volt_beta);
      udc = longint'(r.bus_voltage);
      kua = 113512 * ua;
      ubs = ub * 65536;
      code = {(-kua - ubs) > 0, (kua - ubs) > 0, ub >= 0};
      case (code)
         SIGN_110: sec = SECTOR_2;
         SIGN_260: sec = SECTOR_6;
         SIGN_220: sec = SECTOR_4;
         SIGN_170: sec = SECTOR_3;
         SIGN_290: sec = SECTOR_5;
         default:  sec = SECTOR_1;
      endcase
      o = '0;
      o.sector = sec;
      if (udc == 0) begin
         o.bus_fault = 1'b1;
         o.cmp_a = per >> 1;
         o.cmp_b = per >> 1;
         o.cmp_c = per >> 1;
         return o;
      end
      kub = 113512 * ub;
      a3 = 3 * ua * 65536;
      nx = 2 * kub;
      ny = kub + a3;
      nz = kub - a3;
      d = udc * 2 * 65536;
      case (sec)
         SECTOR_1: begin n1 = -nz; n2 = nx; end
         SECTOR_2: begin n1 = nz; n2 = ny; end
         SECTOR_3: begin n1 = nx; n2 = -ny; end
         SECTOR_4: begin n1 = -nx; n2 = nz; end
         SECTOR_5: begin n1 = -ny; n2 = -nz; end
         default:  begin n1 = ny; n2 = -nx; end
      endcase
      den = d;
      if (n1 + n2 > d) begin
         o.overmodulated = 1'b1;
         den = n1 + n2;
      end
      t1 = dwell_fraction(n1, den);
      t2 = dwell_fraction(n2, den);
      ta = 65536 - t1 - t2;
      tb = ta + 2 * t1;
      tc = tb + 2 * t2;
      pa = phase_count(ta, per);
      pb = phase_count(tb, per);
      pc = phase_count(tc, per);
      case (sec)
         SECTOR_1: begin o.cmp_a = pa; o.cmp_b = pb; o.cmp_c = pc; end
         SECTOR_2: begin o.cmp_a = pb; o.cmp_b = pa; o.cmp_c = pc; end
         SECTOR_3: begin o.cmp_a = pc; o.cmp_b = pa; o.cmp_c = pb; end
         SECTOR_4: begin o.cmp_a = pc; o.cmp_b = pb; o.cmp_c = pa; end
         SECTOR_5: begin o.cmp_a = pb; o.cmp_b = pc; o.cmp_c = pa; end
         default:  begin o.cmp_a = pa; o.cmp_b = pc; o.cmp_c = pb; end
      endcase
      return o;
   endfunction

   task automatic send_ref(req_type r);
      int gap;
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_checked(req_type r, bit typed, rsp_type ans);
      rsp_type p;
      p = svpwm_compares(r, period_shadow);
      if (typed && p !== ans) begin
         $error("predictor row mismatch: expected %h actual %h", ans, p);
         fail_count++;
      end
      pending_cmps.push_back(typed ? ans : p);
      send_ref(r);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_cmps.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_period(logic [15:0] v);
      drain_all();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      period_shadow = v;
   endtask

   function automatic req_type random_ref();
      req_type r;
      int k;
      r.volt_alpha = 16'($urandom);
      r.volt_beta = 16'($urandom);
      r.bus_voltage = 16'($urandom);
      k = $urandom_range(0, 9);
      if (k < 5) begin
         r.volt_alpha = 16'(int'($urandom_range(0, 1200)) - 600);
         r.volt_beta = 16'(int'($urandom_range(0, 1200)) - 600);
         r.bus_voltage = 16'($urandom_range(400, 2000));
      end else if (k == 5) begin
         r.bus_voltage = '0;
      end else if (k == 6) begin
         r.bus_voltage = 16'($urandom_range(1, 20));
      end
      return r;
   endfunction

   // receiver: random stall per transfer, plus a long hold-off on request
   initial begin
      int w;
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else begin
            w = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w != 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmps.size() == 0) begin
            $error("unexpected transfer on rsp: %h", rsp_data);
            fail_count++;
         end else begin
            e = pending_cmps.pop_front();
            if (rsp_data.cmp_a !== e.cmp_a) begin
               $error("cmp_a expected %0d actual %0d", e.cmp_a, rsp_data.cmp_a); fail_count++;
            end
            if (rsp_data.cmp_b !== e.cmp_b) begin
               $error("cmp_b expected %0d actual %0d", e.cmp_b, rsp_data.cmp_b); fail_count++;
            end
            if (rsp_data.cmp_c !== e.cmp_c) begin
               $error("cmp_c expected %0d actual %0d", e.cmp_c, rsp_data.cmp_c); fail_count++;
            end
            if (rsp_data.sector !== e.sector) begin
               $error("sector expected %0d actual %0d", e.sector, rsp_data.sector); fail_count++;
            end
            if (rsp_data.overmodulated !== e.overmodulated) begin
               $error("overmodulated expected %0d actual %0d", e.overmodulated,
                      rsp_data.overmodulated);
               fail_count++;
            end
            if (rsp_data.bus_fault !== e.bus_fault) begin
               $error("bus_fault expected %0d actual %0d", e.bus_fault, rsp_data.bus_fault);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("space_vector_pwm_compare verification failed");
         $finish;
      end
   end

   function automatic row_type mk(int a, int b, int u, bit typed, rsp_type ans);
      row_type r;
      r.stim.volt_alpha = 16'(a);
      r.stim.volt_beta = 16'(b);
      r.stim.bus_voltage = 16'(u);
      r.has_answer = typed;
      r.answer = ans;
      return r;
   endfunction

   initial begin
      row_type rows[$];
      rsp_type nil;
      nil = '0;
      // zero bus gives half period and fault; zero reference is a sector two null vector
      rows.push_back(mk(0, 0, 0, 1, '{16'd2500, 16'd2500, 16'd2500, SECTOR_2, 1'b0, 1'b1}));
      rows.push_back(mk(0, 0, 1000, 1, '{16'd2500, 16'd2500, 16'd2500, SECTOR_2, 1'b0, 1'b0}));
      rows.push_back(mk(-32768, -32768, 0, 0, nil));
      rows.push_back(mk(32767, 32767, 65535, 0, nil));
      rows.push_back(mk(32767, 0, 1, 0, nil));
      rows.push_back(mk(-32768, 0, 1, 0, nil));
      rows.push_back(mk(0, 32767, 1, 0, nil));
      rows.push_back(mk(0, -32768, 65535, 0, nil));
      rows.push_back(mk(300, 100, 1000, 0, nil));
      rows.push_back(mk(0, 300, 1000, 0, nil));
      rows.push_back(mk(-300, 100, 1000, 0, nil));
      rows.push_back(mk(-300, -100, 1000, 0, nil));
      rows.push_back(mk(0, -300, 1000, 0, nil));
      rows.push_back(mk(300, -100, 1000, 0, nil));
      rows.push_back(mk(900, 900, 1000, 0, nil));
      rows.push_back(mk(-1, -1, 65535, 0, nil));
      rows.push_back(mk(1, -1, 2, 0, nil));
      rows.push_back(mk(-21846, 21845, 43690, 0, nil));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_checked(rows[i].stim, rows[i].has_answer, rows[i].answer);

      // fill the pipeline while the receiver holds off
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 60; i++) send_checked(random_ref(), 0, nil);
      join

      foreach (rows[i]) begin
         if (i == 0) write_period(16'd0);
         send_checked(rows[i].stim, 0, nil);
      end
      write_period(16'd1);
      for (int i = 0; i < 20; i++) send_checked(random_ref(), 0, nil);
      write_period(16'd65535);
      foreach (rows[i]) send_checked(rows[i].stim, 0, nil);

      for (int ph = 0; ph < 5; ph++) begin
         write_period(ph == 4 ? PERIOD_RESET : 16'($urandom_range(1, 65535)));
         for (int i = 0; i < 320; i++) send_checked(random_ref(), 0, nil);
      end

      drain_all();
      if (fail_count == 0)
         $display("space_vector_pwm_compare verification clean");
      else
         $display("space_vector_pwm_compare verification failed");
      $finish;
   end

endmodule
